// File: rtl/crc16d_pkg.sv
// Shared types, reset values and the CRC-16 byte update for the packet deframer.
package crc16d_pkg;

  localparam logic [7:0]  START_BYTE_RESET = 8'hA1;
  localparam logic [7:0]  MAX_LENGTH_RESET = 8'd200;
  localparam logic [15:0] CRC_SEED_RESET   = 16'hFFFF;

  localparam logic [1:0] REG_START_BYTE = 2'd0;
  localparam logic [1:0] REG_MAX_LENGTH = 2'd1;
  localparam logic [1:0] REG_CRC_SEED   = 2'd2;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  max_length;
    logic [15:0] crc_seed;
  } cfg_t;

  // Reflected CRC-16, polynomial 0x8408, one byte per call.
  function automatic logic [15:0] crc_step(input logic [7:0] b, input logic [15:0] crc);
    logic [7:0] x;
    x = b ^ crc[7:0];
    x = x ^ {x[3:0], 4'b0000};
    return {x, crc[15:8]} ^ {12'b0, x[7:4]} ^ {5'b0, x, 3'b000};
  endfunction

endpackage

// File: rtl/crc16d_regs.sv
// APB configuration registers of the packet deframer.
module crc16d_regs (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output crc16d_pkg::cfg_t     cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte <= crc16d_pkg::START_BYTE_RESET;
      cfg.max_length <= crc16d_pkg::MAX_LENGTH_RESET;
      cfg.crc_seed   <= crc16d_pkg::CRC_SEED_RESET;
    end else if (wr) begin
      case (paddr[3:2])
        crc16d_pkg::REG_START_BYTE: cfg.start_byte <= pwdata[7:0];
        crc16d_pkg::REG_MAX_LENGTH: cfg.max_length <= pwdata[7:0];
        crc16d_pkg::REG_CRC_SEED:   cfg.crc_seed   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      crc16d_pkg::REG_START_BYTE: prdata = {24'b0, cfg.start_byte};
      crc16d_pkg::REG_MAX_LENGTH: prdata = {24'b0, cfg.max_length};
      crc16d_pkg::REG_CRC_SEED:   prdata = {16'b0, cfg.crc_seed};
      default:                    prdata = 32'b0;
    endcase
  end

endmodule

// File: rtl/crc16_packet_deframer.sv
// Top level of the CRC-16 packet deframer: header parsing, running CRC and result register.
//
// The block takes one received byte per item and accepts an item in every clock cycle
// unless the output is stalled. It hunts for the start byte, then reads type and length (a
// length over max_length returns it to the hunt) and the two CRC bytes, and passes each
// payload byte out with its index; the item that completes a packet has tlast set and
// reports whether the running CRC matched. The phase, the running CRC and the output
// register load at the edge that accepts an item. The input stays ready while the output
// register is empty or draining, so an output stall stalls the input in the same cycle.
module crc16_packet_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // pkt_type, pkt_length, data_byte, byte_index, crc_ok, zeros
  output logic        m_tlast,   // last
  output logic        m_tuser    // has_byte
);

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_TYPE    = 3'd1;
  localparam logic [2:0] PH_LENGTH  = 3'd2;
  localparam logic [2:0] PH_CRC_LO  = 3'd3;
  localparam logic [2:0] PH_CRC_HI  = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;

  crc16d_pkg::cfg_t cfg;

  logic [2:0]  phase, phase_next;
  logic [7:0]  held_type, held_type_next;
  logic [7:0]  held_length, held_length_next;
  logic [15:0] received_crc, received_crc_next;
  logic [7:0]  payload_count, payload_count_next;
  logic [15:0] running_crc, running_crc_next;

  logic        accept;
  logic [15:0] crc_upd;
  logic [7:0]  count_inc;
  logic        emit;
  logic        res_has, res_last, res_ok;
  logic [7:0]  res_data, res_index;

  crc16d_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign crc_upd   = crc16d_pkg::crc_step(s_tdata, running_crc);
  assign count_inc = payload_count + 8'd1;

  always_comb begin
    phase_next         = phase;
    held_type_next     = held_type;
    held_length_next   = held_length;
    received_crc_next  = received_crc;
    payload_count_next = payload_count;
    running_crc_next   = running_crc;
    emit      = 1'b0;
    res_has   = 1'b0;
    res_data  = 8'd0;
    res_index = 8'd0;
    res_last  = 1'b0;
    res_ok    = 1'b0;
    case (phase)
      PH_HUNT: begin
        if (s_tdata == cfg.start_byte) begin
          running_crc_next = cfg.crc_seed;
          phase_next = PH_TYPE;
        end
      end
      PH_TYPE: begin
        held_type_next = s_tdata;
        running_crc_next = crc_upd;
        phase_next = PH_LENGTH;
      end
      PH_LENGTH: begin
        held_length_next = s_tdata;
        if (s_tdata > cfg.max_length) begin
          phase_next = PH_HUNT;
        end else begin
          running_crc_next = crc_upd;
          payload_count_next = 8'd0;
          phase_next = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        received_crc_next = {8'd0, s_tdata};
        phase_next = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        received_crc_next = {s_tdata, received_crc[7:0]};
        if (held_length == 8'd0) begin
          phase_next = PH_HUNT;
          emit = 1'b1;
          res_last = 1'b1;
          res_ok = (running_crc == {s_tdata, received_crc[7:0]});
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        running_crc_next = crc_upd;
        payload_count_next = count_inc;
        emit = 1'b1;
        res_has = 1'b1;
        res_data = s_tdata;
        res_index = payload_count;
        if (count_inc == held_length) begin
          payload_count_next = 8'd0;
          phase_next = PH_HUNT;
          res_last = 1'b1;
          res_ok = (crc_upd == received_crc);
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      held_type     <= 8'd0;
      held_length   <= 8'd0;
      received_crc  <= 16'd0;
      payload_count <= 8'd0;
      running_crc   <= crc16d_pkg::CRC_SEED_RESET;
    end else if (accept) begin
      phase         <= phase_next;
      held_type     <= held_type_next;
      held_length   <= held_length_next;
      received_crc  <= received_crc_next;
      payload_count <= payload_count_next;
      running_crc   <= running_crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      m_tdata <= {7'b0, res_ok, res_index, res_data, held_length_next, held_type_next};
      m_tlast <= res_last;
      m_tuser <= res_has;
    end
  end

endmodule

// File: rtl/crc16d_checker.sv
// Port-level checks on the packet deframer, bound to the top level.
module crc16d_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("Stalled result item changed.");

  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("Input ready does not follow the output register.");

  a_rise_after_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
    else $error("Result item appeared without an accepted input item.");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && (m_tdata[31:16] == 16'd0))
    else $error("Result without payload byte is not a clean packet end.");

  a_ok_with_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !m_tdata[32])
    else $error("CRC status shown on an item that does not end a packet.");

endmodule

bind crc16_packet_deframer crc16d_checker u_crc16d_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// File: dv/tb_top.sv
// Testbench for crc16_packet_deframer: random and directed byte streams checked by a scoreboard.
`timescale 1ns / 100ps

module tb_top;

  localparam int          CYCLE_LIMIT  = 300000;
  localparam int          DRAIN_CYCLES = 4;
  localparam int          NUM_PHASES   = 6;
  localparam int          PHASE_ITEMS  = 25;
  localparam int          HOLD_CYCLES  = 80;
  localparam logic [15:0] CRC_POLY     = 16'h8408;
  localparam logic [1:0]  REG_UNUSED   = 2'd3;

  typedef enum logic [2:0] {
    PH_HUNT, PH_TYPE, PH_LENGTH, PH_CRC_LO, PH_CRC_HI, PH_PAYLOAD
  } rx_phase_e;

  typedef struct packed {
    logic [7:0] pkt_type;
    logic [7:0] pkt_length;
    logic       has_byte;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic       last;
    logic       crc_ok;
  } deframed_item_t;

  typedef logic [7:0] byte_q_t[$];

  class deframer_scoreboard;
    logic [7:0]     start_byte;
    logic [7:0]     max_length;
    logic [15:0]    crc_seed;
    rx_phase_e      phase;
    logic [7:0]     held_type;
    logic [7:0]     held_length;
    logic [15:0]    received_crc;
    logic [7:0]     payload_count;
    logic [15:0]    running_crc;
    deframed_item_t expected_q[$];
    int             errors;
    int             items_checked;
    int             packets_done;
    int             packets_bad_crc;

    function new();
      start_byte    = crc16d_pkg::START_BYTE_RESET;
      max_length    = crc16d_pkg::MAX_LENGTH_RESET;
      crc_seed      = crc16d_pkg::CRC_SEED_RESET;
      phase         = PH_HUNT;
      held_type     = 8'h00;
      held_length   = 8'h00;
      received_crc  = 16'h0000;
      payload_count = 8'h00;
      running_crc   = crc16d_pkg::CRC_SEED_RESET;
      errors        = 0;
      items_checked = 0;
      packets_done  = 0;
      packets_bad_crc = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        crc16d_pkg::REG_START_BYTE: start_byte = value[7:0];
        crc16d_pkg::REG_MAX_LENGTH: max_length = value[7:0];
        crc16d_pkg::REG_CRC_SEED:   crc_seed   = value[15:0];
        default: ;
      endcase
    endfunction

    function logic [15:0] crc_byte(logic [7:0] b, logic [15:0] crc);
      logic [15:0] c;
      int          i;
      c = crc ^ {8'h00, b};
      for (i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
    endfunction

    function void push_expected(logic has, logic [7:0] data, logic [7:0] idx,
                                logic fin, logic ok);
      deframed_item_t r;
      r.pkt_type   = held_type;
      r.pkt_length = held_length;
      r.has_byte   = has;
      r.data_byte  = has ? data : 8'h00;
      r.byte_index = has ? idx : 8'h00;
      r.last       = fin;
      r.crc_ok     = fin && ok;
      expected_q.push_back(r);
    endfunction

    function void note_byte(logic [7:0] b);
      logic [7:0] idx;
      logic       fin;
      case (phase)
        PH_HUNT: begin
          if (b == start_byte) begin
            running_crc = crc_seed;
            phase = PH_TYPE;
          end
        end
        PH_TYPE: begin
          held_type = b;
          running_crc = crc_byte(b, running_crc);
          phase = PH_LENGTH;
        end
        PH_LENGTH: begin
          held_length = b;
          if (b > max_length) begin
            phase = PH_HUNT;
          end else begin
            running_crc = crc_byte(b, running_crc);
            payload_count = 8'h00;
            phase = PH_CRC_LO;
          end
        end
        PH_CRC_LO: begin
          received_crc = {8'h00, b};
          phase = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          received_crc[15:8] = b;
          if (held_length == 8'h00) begin
            phase = PH_HUNT;
            push_expected(1'b0, 8'h00, 8'h00, 1'b1, running_crc == received_crc);
          end else begin
            phase = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          idx = payload_count;
          running_crc = crc_byte(b, running_crc);
          payload_count = payload_count + 8'd1;
          fin = (payload_count == held_length);
          if (fin) begin
            payload_count = 8'h00;
            phase = PH_HUNT;
          end
          push_expected(1'b1, b, idx, fin, running_crc == received_crc);
        end
        default: phase = PH_HUNT;
      endcase
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [39:0] data, logic tlast, logic tuser);
      deframed_item_t want;
      if (expected_q.size() == 0) begin
        $error("output item with no expectation waiting: tdata 0x%0h", data);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      items_checked++;
      if (want.last) begin
        packets_done++;
        if (!want.crc_ok) packets_bad_crc++;
      end
      check_field("pkt_type", 16'(want.pkt_type), 16'(data[7:0]));
      check_field("pkt_length", 16'(want.pkt_length), 16'(data[15:8]));
      check_field("data_byte", 16'(want.data_byte), 16'(data[23:16]));
      check_field("byte_index", 16'(want.byte_index), 16'(data[31:24]));
      check_field("crc_ok", 16'(want.crc_ok), 16'(data[32]));
      check_field("tdata padding", 16'h0000, 16'(data[39:33]));
      check_field("last", 16'(want.last), 16'(tlast));
      check_field("has_byte", 16'(want.has_byte), 16'(tuser));
    endfunction

    function void finish_check();
      if (expected_q.size() != 0) begin
        $error("%0d expected output items never arrived", expected_q.size());
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // rx_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // pkt_type, pkt_length, data_byte, byte_index, crc_ok, zeros
  logic        m_tlast;   // last
  logic        m_tuser;   // has_byte

  deframer_scoreboard sb = new();
  bit gaps_on = 1'b1;
  bit hold_off_req = 1'b0;
  int packet_items = 0;
  int settings_used = 0;
  int cycle_count;

  crc16_packet_deframer dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast, m_tuser);
      if (s_tvalid && s_tready) sb.note_byte(s_tdata);
    end
  end

  initial begin
    m_tready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        m_tready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped at the cycle limit.");
    $display("status: fail");
    $finish;
  end

  task automatic send_byte(input logic [7:0] value);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic byte_q_t random_body(int len);
    byte_q_t body;
    int      i;
    for (i = 0; i < len; i++) body.push_back(8'($urandom_range(0, 255)));
    return body;
  endfunction

  // Builds a frame under the current settings and sends its first keep bytes (all if negative).
  task automatic send_packet(input logic [7:0] ptype, input logic [7:0] plen,
                             input byte_q_t body, input bit bad_crc, input int keep);
    byte_q_t     frame;
    logic [15:0] crc;
    int          i;
    crc = sb.crc_byte(ptype, sb.crc_seed);
    crc = sb.crc_byte(plen, crc);
    foreach (body[j]) crc = sb.crc_byte(body[j], crc);
    if (bad_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    frame.push_back(sb.start_byte);
    frame.push_back(ptype);
    frame.push_back(plen);
    if (plen <= sb.max_length) begin
      frame.push_back(crc[7:0]);
      frame.push_back(crc[15:8]);
      foreach (body[j]) frame.push_back(body[j]);
    end
    for (i = 0; i < frame.size() && (keep < 0 || i < keep); i++) begin
      send_byte(frame[i]);
      packet_items++;
    end
  endtask

  initial begin
    byte_q_t     none;
    byte_q_t     body;
    int          p;
    int          r;
    int          len;
    int          cap;
    int          phase_goal;
    logic [7:0]  cfg_start;
    logic [7:0]  cfg_max;
    logic [15:0] cfg_seed;

    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= 4'h0;
    pwdata   <= 32'h0;
    s_tvalid <= 1'b0;
    s_tdata  <= 8'h00;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed part under the reset settings.
    send_byte(8'h00);
    send_packet(8'h00, 8'd0, none, 1'b0, -1);
    send_packet(8'hFF, 8'd0, none, 1'b1, -1);
    body.push_back(8'h00);
    body.push_back(crc16d_pkg::START_BYTE_RESET);
    body.push_back(8'hFF);
    send_packet(8'h5A, 8'd3, body, 1'b0, -1);
    send_packet(8'h3C, 8'hFF, none, 1'b0, -1);
    send_packet(8'hC3, 8'd1, random_body(1), 1'b0, -1);

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin
          cfg_start = crc16d_pkg::START_BYTE_RESET;
          cfg_max   = crc16d_pkg::MAX_LENGTH_RESET;
          cfg_seed  = crc16d_pkg::CRC_SEED_RESET;
        end
        1: begin
          cfg_start = 8'h00;
          cfg_max   = 8'h00;
          cfg_seed  = 16'h0000;
        end
        2: begin
          cfg_start = 8'hFF;
          cfg_max   = 8'hFF;
          cfg_seed  = 16'($urandom_range(0, 65535));
        end
        3: begin
          cfg_start = 8'($urandom_range(128, 255));
          cfg_max   = 8'($urandom_range(1, 100));
          cfg_seed  = 16'($urandom_range(0, 65535));
        end
        default: begin
          cfg_start = 8'($urandom_range(0, 255));
          cfg_max   = 8'($urandom_range(0, 255));
          cfg_seed  = 16'($urandom_range(0, 65535));
        end
      endcase
      write_reg(crc16d_pkg::REG_START_BYTE, {24'h0, cfg_start});
      write_reg(crc16d_pkg::REG_MAX_LENGTH, {24'h0, cfg_max});
      write_reg(crc16d_pkg::REG_CRC_SEED, {16'h0, cfg_seed});
      if (p == 0) write_reg(REG_UNUSED, $urandom);
      settings_used++;
      gaps_on = (p != NUM_PHASES - 1);
      if (p == 0) hold_off_req = 1'b1;
      if (p == 2) send_packet(8'($urandom_range(0, 255)), 8'hFF, random_body(255), 1'b0, -1);

      phase_goal = packet_items + PHASE_ITEMS;
      while (packet_items < phase_goal) begin
        r = $urandom_range(0, 99);
        cap = (sb.max_length < 12) ? sb.max_length : 12;
        if (r >= 95) cap = (sb.max_length < 40) ? sb.max_length : 40;
        len = $urandom_range(0, cap);
        if (r < 8) begin
          send_byte(8'($urandom_range(0, 255)));
        end else if (r < 14) begin
          send_packet(8'($urandom_range(0, 255)), 8'(len), random_body(len), 1'b0,
                      $urandom_range(1, 5));
        end else if (r < 22 && sb.max_length != 8'hFF) begin
          if (sb.start_byte > sb.max_length && $urandom_range(0, 1) == 1)
            len = sb.start_byte;
          else
            len = $urandom_range(sb.max_length + 1, 255);
          send_packet(8'($urandom_range(0, 255)), 8'(len), none, 1'b0, -1);
        end else begin
          send_packet(8'($urandom_range(0, 255)), 8'(len), random_body(len), r < 32, -1);
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.finish_check();
    $display("Checked %0d output items from %0d framed input bytes over %0d settings.",
             sb.items_checked, packet_items, settings_used);
    $display("Completed %0d packets, %0d of them with a CRC mismatch.",
             sb.packets_done, sb.packets_bad_crc);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/crc16d_pkg.sv
rtl/crc16d_regs.sv
rtl/crc16_packet_deframer.sv
rtl/crc16d_checker.sv
dv/tb_top.sv
